// File: sv/tacr_pkg.sv
// Shared types and constants of the tile average downsampler.
// Field widths, configuration register indexes and the pipeline metadata struct.
// Depends on nothing.
package tacr_pkg;

  localparam int PIX_W  = 8;
  localparam int AVG_W  = 8;
  localparam int RANK_W = 7;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 9;
  localparam int X_W    = 11;
  localparam int Y_W    = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [X_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [Y_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position and edge flags that travel with a tile through the pipeline.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             frame_end;
  } tile_meta_t;

  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic [RANK_W-1:0] rank;
    tile_meta_t        meta;
  } result_t;

endpackage

// File: sv/tacr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
// Depends on nothing.
module tacr_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tile_average_to_char_rank.sv
// Tile average downsampler: per-tile rounded mean and brightness rank.
// Depends on tacr_pkg and tacr_ram.
//
// Usage:
// Pixels arrive in raster order on the pixel channel (pixel_valid/pixel_ready),
// one 8-bit gray value per transaction. The frame is image_width by image_height
// pixels and is cut into TILE_W x TILE_H tiles. On the bottom right pixel of each
// whole tile the block emits one transaction on the result channel
// (result_valid/result_ready) with the rounded tile mean, its rank in
// 0..CHAR_COUNT-1, the tile position and row/frame end flags. Partial tiles at
// the right or bottom edge and tile columns past MAX_TILE_COLS give nothing.
// Throughput is one pixel per cycle while pixel_ready is high. After its last
// pixel is accepted, a result passes the column-sum memory read, the
// read-modify-write, the constant divide stages, the rank multiply and the
// output queue, in that order. The column sums live in a single RAM with a
// registered read; back-to-back updates of one column are forwarded around it.
// Up to eight results may wait in the output queue; pixel_ready drops only when
// eight results are accepted but not yet taken, so a stalled receiver throttles
// the source. Reset returns the pixel position to the frame origin and the size
// registers to 640 x 480; no memory clearing is needed. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and do not move the position.
module tile_average_to_char_rank #(
  parameter int TILE_W        = 10,
  parameter int TILE_H        = 8,
  parameter int MAX_TILE_COLS = 128,
  parameter int CHAR_COUNT    = 95
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tacr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tacr_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [tacr_pkg::PIX_W-1:0]         pixel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [tacr_pkg::AVG_W-1:0]         tile_average,
  output logic [tacr_pkg::RANK_W-1:0]        char_rank,
  output logic [tacr_pkg::COL_W-1:0]         tile_col,
  output logic [tacr_pkg::ROW_W-1:0]         tile_row,
  output logic                               row_end,
  output logic                               frame_end
);

  localparam int NPIX   = TILE_W * TILE_H;
  localparam int DIV    = 2 * NPIX;
  localparam int SUM_W  = $clog2(255 * NPIX + 1);
  localparam int NUM_W  = SUM_W + 1;
  localparam int AW     = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int CXW    = (TILE_W > 1) ? $clog2(TILE_W) : 1;
  localparam int CYW    = (TILE_H > 1) ? $clog2(TILE_H) : 1;
  localparam int CMP_W  = 13;
  localparam int PROD_W = 16;
  localparam int QDEPTH = 8;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration registers.
  logic [tacr_pkg::X_W-1:0] image_width;
  logic [tacr_pkg::Y_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tacr_pkg::WIDTH_RESET;
      image_height <= tacr_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (tacr_pkg::cfg_reg_t'(cfg_index))
        tacr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[tacr_pkg::X_W-1:0];
        tacr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[tacr_pkg::Y_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters. Tile column/row and the offset inside the tile are kept
  // alongside the raw position so no division by the tile size is needed.
  logic [tacr_pkg::X_W-1:0] pos_x, tile_x0, tcol;
  logic [tacr_pkg::Y_W-1:0] pos_y, tile_y0, trow;
  logic [CXW-1:0]           cx;
  logic [CYW-1:0]           cy;

  logic pix_acc;
  logic kept, first_pix, last_pix, is_result, rend0, fend0;
  logic row_wrap, frame_wrap;

  assign pix_acc = pixel_valid && pixel_ready;

  always_comb begin
    logic [CMP_W-1:0] xe, ye, xe2, ye2, wd, ht;
    wd  = CMP_W'(image_width);
    ht  = CMP_W'(image_height);
    xe  = CMP_W'(tile_x0) + CMP_W'(TILE_W);
    ye  = CMP_W'(tile_y0) + CMP_W'(TILE_H);
    xe2 = CMP_W'(tile_x0) + CMP_W'(2 * TILE_W);
    ye2 = CMP_W'(tile_y0) + CMP_W'(2 * TILE_H);
    // A tile is kept when it lies wholly inside the frame and below the column limit.
    kept      = (CMP_W'(tcol) < CMP_W'(MAX_TILE_COLS)) && (xe <= wd) && (ye <= ht);
    first_pix = (cx == '0) && (cy == '0);
    last_pix  = (cx == CXW'(TILE_W - 1)) && (cy == CYW'(TILE_H - 1));
    is_result = kept && last_pix;
    // The next tile column does not exist when it passes the limit or the frame edge.
    rend0 = (CMP_W'(tcol) + CMP_W'(1) == CMP_W'(MAX_TILE_COLS)) || (xe2 > wd);
    fend0 = rend0 && (ye2 > ht);
    row_wrap   = (CMP_W'(pos_x) + CMP_W'(1)) >= wd;
    frame_wrap = (CMP_W'(pos_y) + CMP_W'(1)) >= ht;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      tile_x0 <= '0;
      tile_y0 <= '0;
      tcol    <= '0;
      trow    <= '0;
      cx      <= '0;
      cy      <= '0;
    end else if (pix_acc) begin
      if (row_wrap) begin
        pos_x   <= '0;
        tile_x0 <= '0;
        tcol    <= '0;
        cx      <= '0;
        if (frame_wrap) begin
          pos_y   <= '0;
          tile_y0 <= '0;
          trow    <= '0;
          cy      <= '0;
        end else begin
          pos_y <= pos_y + 1'b1;
          if (cy == CYW'(TILE_H - 1)) begin
            cy      <= '0;
            trow    <= trow + 1'b1;
            tile_y0 <= tile_y0 + tacr_pkg::Y_W'(TILE_H);
          end else begin
            cy <= cy + 1'b1;
          end
        end
      end else begin
        pos_x <= pos_x + 1'b1;
        if (cx == CXW'(TILE_W - 1)) begin
          cx      <= '0;
          tcol    <= tcol + 1'b1;
          tile_x0 <= tile_x0 + tacr_pkg::X_W'(TILE_W);
        end else begin
          cx <= cx + 1'b1;
        end
      end
    end
  end

  // Result credit: results accepted on the input but not yet delivered.
  logic [QCW-1:0] pending;
  logic           res_pop;

  assign pixel_ready = (pending != QCW'(QDEPTH));
  assign res_pop     = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      unique case ({pix_acc && is_result, res_pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // Stage 1: column sum read-modify-write.
  logic                      s1_v, s1_first, s1_last;
  logic [tacr_pkg::PIX_W-1:0] s1_pix;
  logic [AW-1:0]             s1_addr;
  tacr_pkg::tile_meta_t      meta0, s1_meta;
  logic [SUM_W-1:0]          ram_rdata, s1_base, s1_sum;
  logic                      fwd_v;
  logic [AW-1:0]             fwd_addr;
  logic [SUM_W-1:0]          fwd_sum;

  assign meta0.col       = tcol[tacr_pkg::COL_W-1:0];
  assign meta0.row       = trow[tacr_pkg::ROW_W-1:0];
  assign meta0.row_end   = rend0;
  assign meta0.frame_end = fend0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      fwd_v <= 1'b0;
    end else begin
      s1_v  <= pix_acc && kept;
      fwd_v <= s1_v;
    end
    s1_first <= first_pix;
    s1_last  <= last_pix;
    s1_pix   <= pixel;
    s1_addr  <= tcol[AW-1:0];
    s1_meta  <= meta0;
    fwd_addr <= s1_addr;
    fwd_sum  <= s1_sum;
  end

  // The RAM returns old data when the entry was written in the same cycle as
  // the read, so the previous write is forwarded.
  always_comb begin
    if (s1_first) begin
      s1_base = '0;
    end else if (fwd_v && (fwd_addr == s1_addr)) begin
      s1_base = fwd_sum;
    end else begin
      s1_base = ram_rdata;
    end
    s1_sum = s1_base + SUM_W'(s1_pix);
  end

  tacr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_TILE_COLS)
  ) u_sums (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_addr),
    .wdata (s1_sum),
    .raddr (tcol[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Stage 2: rounding numerator 2*sum + N.
  logic                 s2_v;
  logic [NUM_W-1:0]     s2_num;
  tacr_pkg::tile_meta_t s2_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v && s1_last;
    end
    s2_num  <= {s1_sum, 1'b0} + NUM_W'(NPIX);
    s2_meta <= s1_meta;
  end

  // Stages 3 and 4: restoring division by 2*N, four quotient bits per stage.
  logic                 s3_v, s4_v;
  logic [NUM_W-1:0]     s3_rem;
  logic [3:0]           s3_qhi;
  logic [tacr_pkg::AVG_W-1:0] s4_avg;
  tacr_pkg::tile_meta_t s3_meta, s4_meta;
  logic [NUM_W-1:0]     rem_hi, rem_lo;
  logic [3:0]           q_hi, q_lo;

  always_comb begin
    rem_hi = s2_num;
    q_hi   = '0;
    for (int i = 7; i >= 4; i--) begin
      if (rem_hi >= (NUM_W'(DIV) << i)) begin
        rem_hi     = rem_hi - (NUM_W'(DIV) << i);
        q_hi[i-4]  = 1'b1;
      end
    end
    rem_lo = s3_rem;
    q_lo   = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rem_lo >= (NUM_W'(DIV) << i)) begin
        rem_lo  = rem_lo - (NUM_W'(DIV) << i);
        q_lo[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s3_rem  <= rem_hi;
    s3_qhi  <= q_hi;
    s3_meta <= s2_meta;
    s4_avg  <= {s3_qhi, q_lo};
    s4_meta <= s3_meta;
  end

  // Stage 5: rank product; the divide by 255 is folded into the queue write.
  logic                       s5_v;
  logic [tacr_pkg::AVG_W-1:0] s5_avg;
  logic [PROD_W-1:0]          s5_prod;
  tacr_pkg::tile_meta_t       s5_meta;
  logic [PROD_W-1:0]          rank_full;
  tacr_pkg::result_t          q_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= s4_v;
    end
    s5_avg  <= s4_avg;
    s5_prod <= PROD_W'(s4_avg) * PROD_W'(CHAR_COUNT - 1);
    s5_meta <= s4_meta;
  end

  // Exact x/255 for x below 65280.
  assign rank_full = (s5_prod + PROD_W'(1) + (s5_prod >> 8)) >> 8;
  assign q_in.avg  = s5_avg;
  assign q_in.rank = rank_full[tacr_pkg::RANK_W-1:0];
  assign q_in.meta = s5_meta;

  // Output queue.
  tacr_pkg::result_t q_mem [QDEPTH];
  logic [QPW-1:0]    q_wptr, q_rptr;
  logic [QCW-1:0]    q_count;

  always_ff @(posedge clk) begin
    if (s5_v) begin
      q_mem[q_wptr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (s5_v) begin
        q_wptr <= q_wptr + 1'b1;
      end
      if (res_pop) begin
        q_rptr <= q_rptr + 1'b1;
      end
      unique case ({s5_v, res_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign result_valid = (q_count != '0);
  assign tile_average = q_mem[q_rptr].avg;
  assign char_rank    = q_mem[q_rptr].rank;
  assign tile_col     = q_mem[q_rptr].meta.col;
  assign tile_row     = q_mem[q_rptr].meta.row;
  assign row_end      = q_mem[q_rptr].meta.row_end;
  assign frame_end    = q_mem[q_rptr].meta.frame_end;

`ifndef NO_ASSERTIONS
  // The credit counter must keep the queue from ever overflowing.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s5_v && !res_pop |-> q_count != QCW'(QDEPTH))
    else $error("output queue written while full");

  // Every queued result was first counted as pending.
  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    q_count <= pending)
    else $error("queue holds more results than were accepted");

  // An accepted result pixel leaves at least one result pending.
  a_result_reserved: assert property (@(posedge clk) disable iff (rst)
    pix_acc && is_result |=> pending != '0)
    else $error("accepted result was not reserved");
`endif

endmodule
